[src/ecs_pkg.sv]
// ============================================================================
// ecs_pkg: shared types and constants of the encoder edge counter
// Widths, fixed-point scale factors, operation codes and state encodings.
// ============================================================================
`default_nettype none

package ecs_pkg;

    // Counter and output widths
    localparam int COUNT_W   = 32;
    localparam int OUT_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int PPR_W     = 16;
    localparam int DT_W      = 32;
    localparam int OP_W      = 2;

    // Configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] CFG_ADDR_PPR = PADDR_W'(0);
    localparam logic [PPR_W-1:0]   PPR_RESET    = PPR_W'(1024);

    // Ratio datapath: value = round(qmag * factor / (den * 2^SHIFT))
    localparam int QMAG_W = COUNT_W - 1;           // half of a count magnitude
    localparam int FACT_W = 55;                    // 2*pi*2^32*1e6 fits here
    localparam int PROD_W = FACT_W + QMAG_W;       // qmag * factor
    localparam int DEN_W  = PPR_W + DT_W;          // ppr * delta time
    localparam int SHIFT  = 32 - FRAC_BITS;
    localparam int Y_W    = OUT_W + 32 - FRAC_BITS; // quotient bits kept below overflow
    localparam int QUO_W  = Y_W - SHIFT + 1;       // quotient bits down to the round bit
    localparam int MUL_STEPS = QMAG_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [FACT_W-1:0] TWO_PI_Q32   = FACT_W'(64'd26986075409);
    localparam logic [FACT_W-1:0] SPEED_FACTOR = FACT_W'(64'd26986075409000000);

    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'd1 << (OUT_W - 1));

    typedef enum logic [OP_W-1:0] {
        OP_EDGE         = 2'd0,
        OP_CLR_INTERVAL = 2'd1,
        OP_CLR_TOTAL    = 2'd2,
        OP_READ         = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_START,
        CTL_RUN,
        CTL_WAIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        RAT_IDLE,
        RAT_MUL,
        RAT_CHK,
        RAT_DIV,
        RAT_FIN
    } rat_state_t;

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] value;
    } ratio_res_t;

endpackage

`default_nettype wire

[src/ecs_count.sv]
// ============================================================================
// ecs_count: direction latch and edge counters
// Applies one operation per transfer to the interval and total counters.
// ============================================================================
`default_nettype none

module ecs_count
    import ecs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      fire,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic                      a_level,
    input  wire logic                      b_level,
    output logic signed [COUNT_W-1:0]      interval,
    output logic signed [COUNT_W-1:0]      total
);

    logic               last_a_reg, last_a_next;
    logic               forward_reg, forward_next;
    logic [COUNT_W-1:0] interval_reg, interval_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] step;

    always_comb
    begin
        last_a_next   = last_a_reg;
        forward_next  = forward_reg;
        interval_next = interval_reg;
        total_next    = total_reg;
        step          = '0;
        if (fire)
        begin
            unique case (op_t'(operation))
                OP_EDGE:
                begin
                    // latch direction from B on a rising A edge
                    if (!last_a_reg && a_level)
                        forward_next = b_level;
                    last_a_next   = a_level;
                    step          = forward_next ? COUNT_W'(1) : '1;
                    interval_next = interval_reg + step;
                    total_next    = total_reg + step;
                end
                OP_CLR_INTERVAL: interval_next = '0;
                OP_CLR_TOTAL:    total_next    = '0;
                OP_READ:         ;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg   <= 1'b0;
            forward_reg  <= 1'b1;
            interval_reg <= '0;
            total_reg    <= '0;
        end
        else
        begin
            last_a_reg   <= last_a_next;
            forward_reg  <= forward_next;
            interval_reg <= interval_next;
            total_reg    <= total_next;
        end
    end

    assign interval = interval_reg;
    assign total    = total_reg;

endmodule

`default_nettype wire

[src/ecs_ratio.sv]
// ============================================================================
// ecs_ratio: bit-serial scaled ratio unit
// Shift-add multiplies qmag by a factor and ppr by a time step, then runs a
// restoring divide one quotient bit per cycle, rounds and saturates.
// ============================================================================
`default_nettype none

module ecs_ratio
    import ecs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QMAG_W-1:0] qmag,
    input  wire logic              neg,
    input  wire logic [FACT_W-1:0] factor,
    input  wire logic [PPR_W-1:0]  den_a,
    input  wire logic [DT_W-1:0]   den_b,
    output logic                   done,
    output ratio_res_t             res
);

    rat_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DT_W-1:0]    b_reg, b_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               ovf_reg, ovf_next;
    logic               done_reg, done_next;
    ratio_res_t         res_reg, res_next;

    logic [FACT_W:0]    psum;
    logic [DT_W:0]      dsum;
    logic [DEN_W:0]     tdiv;
    logic [DEN_W:0]     tsub;
    logic               ge;
    logic [QUO_W:0]     rinc;
    logic [QUO_W-1:0]   rounded;
    logic [QUO_W-1:0]   limit;
    logic               sat;
    logic [OUT_W-1:0]   mag;

    // Arithmetic of the current step
    always_comb
    begin
        psum    = {1'b0, prod_reg[PROD_W-1:QMAG_W]}
                + (prod_reg[0] ? {1'b0, factor} : '0);
        dsum    = {1'b0, den_reg[DEN_W-1:PPR_W]} + (den_reg[0] ? {1'b0, b_reg} : '0);
        tdiv    = {rem_reg, prod_reg[Y_W-1]};
        tsub    = tdiv - {1'b0, den_reg};
        ge      = tdiv >= {1'b0, den_reg};
        rinc    = {1'b0, quo_reg} + (QUO_W+1)'(1);
        rounded = rinc[QUO_W:1];
        limit   = neg_reg ? LIM_NEG : LIM_POS;
        sat     = !zero_reg && (ovf_reg || rounded > limit);
        if (zero_reg)
            mag = '0;
        else if (sat)
            mag = limit[OUT_W-1:0];
        else
            mag = rounded[OUT_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RAT_IDLE: if (start) state_next = RAT_MUL;
            RAT_MUL:  if (cnt_reg == STEP_W'(MUL_STEPS - 1)) state_next = RAT_CHK;
            RAT_CHK:  state_next = RAT_DIV;
            RAT_DIV:  if (cnt_reg == STEP_W'(DIV_STEPS - 1)) state_next = RAT_FIN;
            RAT_FIN:  state_next = RAT_IDLE;
            default:  state_next = RAT_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        den_next  = den_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        ovf_next  = ovf_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        unique case (state_reg)
            RAT_IDLE:
            begin
                if (start)
                begin
                    prod_next = {{FACT_W{1'b0}}, qmag};
                    den_next  = {{DT_W{1'b0}}, den_a};
                    b_next    = den_b;
                    neg_next  = neg;
                    zero_next = (qmag == '0);
                    cnt_next  = '0;
                end
            end
            RAT_MUL:
            begin
                // product shifts right, one multiplier bit per cycle
                prod_next = {psum, prod_reg[QMAG_W-1:1]};
                if (cnt_reg < STEP_W'(PPR_W))
                    den_next = {dsum, den_reg[PPR_W-1:1]};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            RAT_CHK:
            begin
                // quotient would not fit below 2^Y_W
                ovf_next = {{(DEN_W-(PROD_W-Y_W)){1'b0}}, prod_reg[PROD_W-1:Y_W]} >= den_reg;
                rem_next = {{(DEN_W-(PROD_W-Y_W)){1'b0}}, prod_reg[PROD_W-1:Y_W]};
                cnt_next = '0;
            end
            RAT_DIV:
            begin
                rem_next  = ge ? tsub[DEN_W-1:0] : tdiv[DEN_W-1:0];
                quo_next  = {quo_reg[QUO_W-2:0], ge};
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + STEP_W'(1);
            end
            RAT_FIN:
            begin
                res_next.sat   = sat;
                res_next.value = neg_reg ? (OUT_W'(0) - mag) : mag;
                done_next      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RAT_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[src/encoder_edge_counter_speed.sv]
// ============================================================================
// encoder_edge_counter_speed: quadrature edge counter with angle and speed
// Counts encoder edges and reports counts, angle and speed in Q16.16.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   edge event, clear interval count, clear total count or read. Every input
//   transfer produces exactly one result on the output channel (out_valid /
//   out_stall): both counts after the operation, angle of the total count,
//   speed of the interval count over delta_time_us, and a saturation flag.
//   A new item is taken only once the previous result is loaded. The run
//   time is set by the bit-serial ratio units: 31 shift-add multiply steps
//   and 33 restoring divide steps, angle and speed run side by side.
//   A finished result sits in the output register; the next item is accepted
//   while it waits. If the receiver holds out_stall when a new result is
//   ready, the block holds that result internally and keeps in_stall high.
//   The user must write pulses_per_rev over the APB port only while idle
//   (reset 1024); the block itself does not enforce this. Reset clears both
//   counters, sets direction forward and empties the output.
// ============================================================================
`default_nettype none

module encoder_edge_counter_speed
    import ecs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]             prdata,
    output logic                           pready,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic                      a_level,
    input  wire logic                      b_level,
    input  wire logic [DT_W-1:0]           delta_time_us,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [OUT_W-1:0]        interval_count,
    output logic signed [OUT_W-1:0]        total_count,
    output logic signed [OUT_W-1:0]        angle_position,
    output logic signed [OUT_W-1:0]        angle_speed,
    output logic                           saturated
);

    ctl_state_t                 state_reg, state_next;
    logic [PPR_W-1:0]           ppr_reg;
    logic [DT_W-1:0]            dt_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]    interval_out_reg, total_out_reg;
    logic signed [OUT_W-1:0]    angle_out_reg, speed_out_reg;
    logic                       sat_out_reg;

    logic                       in_fire;
    logic                       cfg_write;
    logic                       out_free;
    logic                       start_ratio;
    logic                       out_load;
    logic [PPR_W-1:0]           ppr_eff;

    logic signed [COUNT_W-1:0]  interval;
    logic signed [COUNT_W-1:0]  total;
    logic [COUNT_W-1:0]         interval_mag, total_mag;

    logic                       angle_done, speed_done;
    ratio_res_t                 angle_res, speed_res;

    assign in_fire   = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ppr_eff   = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_PPR) ? PDATA_W'(ppr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ppr_reg <= PPR_RESET;
        else if (cfg_write && paddr == CFG_ADDR_PPR)
            ppr_reg <= pwdata[PPR_W-1:0];
    end

    ecs_count u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .operation (operation),
        .a_level   (a_level),
        .b_level   (b_level),
        .interval  (interval),
        .total     (total)
    );

    assign interval_mag = interval[COUNT_W-1] ? (COUNT_W'(0) - interval) : interval;
    assign total_mag    = total[COUNT_W-1]    ? (COUNT_W'(0) - total)    : total;

    ecs_ratio u_angle (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ratio),
        .qmag   (total_mag[COUNT_W-1:1]),
        .neg    (total[COUNT_W-1]),
        .factor (TWO_PI_Q32),
        .den_a  (ppr_eff),
        .den_b  (DT_W'(1)),
        .done   (angle_done),
        .res    (angle_res)
    );

    ecs_ratio u_speed (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ratio),
        .qmag   (interval_mag[COUNT_W-1:1]),
        .neg    (interval[COUNT_W-1]),
        .factor (SPEED_FACTOR),
        .den_a  (ppr_eff),
        .den_b  (dt_reg),
        .done   (speed_done),
        .res    (speed_res)
    );

    // Control: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:  if (in_fire) state_next = CTL_START;
            CTL_START: state_next = CTL_RUN;
            CTL_RUN:
            begin
                if (angle_done)
                    state_next = out_free ? CTL_IDLE : CTL_WAIT;
            end
            CTL_WAIT:  if (out_free) state_next = CTL_IDLE;
            default:   state_next = CTL_IDLE;
        endcase
    end

    // Control: outputs
    always_comb
    begin
        in_stall    = (state_reg != CTL_IDLE);
        start_ratio = (state_reg == CTL_START);
        out_load    = ((state_reg == CTL_RUN) && angle_done && out_free)
                   || ((state_reg == CTL_WAIT) && out_free);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            dt_reg <= delta_time_us;
        if (out_load)
        begin
            interval_out_reg <= interval;
            total_out_reg    <= total;
            angle_out_reg    <= angle_res.value;
            speed_out_reg    <= speed_res.value;
            sat_out_reg      <= angle_res.sat || speed_res.sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign interval_count = interval_out_reg;
    assign total_count    = total_out_reg;
    assign angle_position = angle_out_reg;
    assign angle_speed    = speed_out_reg;
    assign saturated      = sat_out_reg;

    // Both ratio units step in lockstep
    a_ratio_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        angle_done == speed_done)
        else $error("angle and speed units finished in different cycles");

    a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> start_ratio)
        else $error("ratio start did not follow an input transfer");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled output");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        angle_done |-> (state_reg == CTL_RUN))
        else $error("ratio result arrived outside of a run");

endmodule

`default_nettype wire
